// File: hdl/cst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg: shared definitions for the second-tick calendar
// Field widths, field limits, operation codes and the month length function.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Field widths
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 7;

  // Field limits
  localparam logic [SecW-1:0]   SecMax   = 6'd59;
  localparam logic [MinW-1:0]   MinMax   = 6'd59;
  localparam logic [HourW-1:0]  HourMax  = 5'd23;
  localparam logic [DayW-1:0]   DayMin   = 5'd1;
  localparam logic [MonthW-1:0] MonthMin = 4'd1;
  localparam logic [MonthW-1:0] MonthMax = 4'd12;
  localparam logic [YearW-1:0]  YearMax  = 7'd99;

  // Month numbers that need special handling
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;

  // Operation codes
  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  // Last day of a month; every year divisible by four is a leap year
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
                                                   input logic [YearW-1:0]  year);
    logic [DayW-1:0] len;
    if (month == MonthFeb) begin
      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
    end else if (month == MonthApr || month == MonthJun ||
                 month == MonthSep || month == MonthNov) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// File: hdl/calendar_second_tick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_second_tick: calendar counter advanced by one-second ticks
// Counts seconds, minutes, hours, day, month and two-digit year, with load.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one command per
//   transfer: operation_i = tick adds one second with full carry through
//   the calendar, operation_i = load writes all six fields at once, each
//   clamped to its range (the day only raised to 1). Every command returns one
//   result on the output channel (out_valid_o / out_stall_i): the date and time after it.
//   From input transfer to result valid, a command passes the input
//   register, then the carry chain into the counter/result registers.
//   Throughput is one command per cycle while the receiver does not
//   stall; the counters update in the same edge that captures the
//   result, so the next command sees them at once.
//   When the receiver stalls, the result register holds, the input
//   register takes one more command and in_stall_o rises only when both
//   are full. Reset empties both stages and sets the calendar to
//   00:00:00, day 1, month 1, year 0.
// ----------------------------------------------------------------------------
module calendar_second_tick (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       operation_i,
  input  wire logic [cst_pkg::SecW-1:0]   new_second_i,
  input  wire logic [cst_pkg::MinW-1:0]   new_minute_i,
  input  wire logic [cst_pkg::HourW-1:0]  new_hour_i,
  input  wire logic [cst_pkg::DayW-1:0]   new_day_i,
  input  wire logic [cst_pkg::MonthW-1:0] new_month_i,
  input  wire logic [cst_pkg::YearW-1:0]  new_year_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [cst_pkg::SecW-1:0]        second_o,
  output logic [cst_pkg::MinW-1:0]        minute_o,
  output logic [cst_pkg::HourW-1:0]       hour_o,
  output logic [cst_pkg::DayW-1:0]        day_o,
  output logic [cst_pkg::MonthW-1:0]      month_o,
  output logic [cst_pkg::YearW-1:0]       year_o
);
  import cst_pkg::*;

  typedef struct packed {
    logic              op;
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   min;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } cmd_t;

  typedef struct packed {
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   min;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } time_t;

  logic  s1_valid_q, s1_valid_d;
  cmd_t  s1_cmd_q;
  logic  out_valid_q, out_valid_d;
  time_t cal_q, cal_d;
  time_t res_q;
  logic  out_free;
  logic  s1_move;
  logic  in_xfer;

  // Handshake: the result stage frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !out_free);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  // Compute the calendar after the staged command
  always_comb begin
    logic [SecW:0]   sec_inc;
    logic [MinW:0]   min_inc;
    logic [HourW:0]  hour_inc;
    logic [DayW:0]   day_inc;
    logic [MonthW:0] month_inc;
    cal_d     = cal_q;
    sec_inc   = {1'b0, cal_q.sec} + 1'b1;
    min_inc   = {1'b0, cal_q.min} + 1'b1;
    hour_inc  = {1'b0, cal_q.hour} + 1'b1;
    day_inc   = {1'b0, cal_q.day} + 1'b1;
    month_inc = {1'b0, cal_q.month} + 1'b1;
    if (s1_cmd_q.op == OpLoad) begin
      // Clamp loaded fields to their ranges
      cal_d.sec   = (s1_cmd_q.sec > SecMax) ? SecMax : s1_cmd_q.sec;
      cal_d.min   = (s1_cmd_q.min > MinMax) ? MinMax : s1_cmd_q.min;
      cal_d.hour  = (s1_cmd_q.hour > HourMax) ? HourMax : s1_cmd_q.hour;
      cal_d.day   = (s1_cmd_q.day < DayMin) ? DayMin : s1_cmd_q.day;
      cal_d.month = (s1_cmd_q.month < MonthMin) ? MonthMin :
                    (s1_cmd_q.month > MonthMax) ? MonthMax : s1_cmd_q.month;
      cal_d.year  = (s1_cmd_q.year > YearMax) ? YearMax : s1_cmd_q.year;
    end else begin
      // Advance one second and ripple the carries upward
      if (sec_inc <= {1'b0, SecMax}) begin
        cal_d.sec = sec_inc[SecW-1:0];
      end else begin
        cal_d.sec = '0;
        if (min_inc <= {1'b0, MinMax}) begin
          cal_d.min = min_inc[MinW-1:0];
        end else begin
          cal_d.min = '0;
          if (hour_inc <= {1'b0, HourMax}) begin
            cal_d.hour = hour_inc[HourW-1:0];
          end else begin
            cal_d.hour = '0;
            if (day_inc <= {1'b0, month_length(cal_q.month, cal_q.year)}) begin
              cal_d.day = day_inc[DayW-1:0];
            end else begin
              cal_d.day = DayMin;
              if (month_inc <= {1'b0, MonthMax}) begin
                cal_d.month = month_inc[MonthW-1:0];
              end else begin
                cal_d.month = MonthMin;
                cal_d.year  = (cal_q.year >= YearMax) ? '0 : cal_q.year + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Control and calendar registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cal_q       <= '{sec: '0, min: '0, hour: '0, day: DayMin, month: MonthMin,
                       year: '0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        cal_q <= cal_d;
      end
    end
  end

  // Capture the command and the result payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q <= '{op: operation_i, sec: new_second_i, min: new_minute_i,
                    hour: new_hour_i, day: new_day_i, month: new_month_i,
                    year: new_year_i};
    end
    if (s1_move) begin
      res_q <= cal_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign second_o    = res_q.sec;
  assign minute_o    = res_q.min;
  assign hour_o      = res_q.hour;
  assign day_o       = res_q.day;
  assign month_o     = res_q.month;
  assign year_o      = res_q.year;

  // Time fields of a result stay in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_o <= SecMax && minute_o <= MinMax && hour_o <= HourMax))
    else $error("result time field out of range");

  // Date fields of a result stay in range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (day_o >= DayMin && month_o >= MonthMin && month_o <= MonthMax &&
                     year_o <= YearMax))
    else $error("result date field out of range");

  // Stall only while the input stage holds a command
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // A result in the output register matches the calendar state
  a_res_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !s1_move) |=> (!out_valid_q || res_q == cal_q))
    else $error("result register disagrees with calendar state");

endmodule
`default_nettype wire
